[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the quaternion to Euler block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

[src/qte_pkg.sv]
// Types, constants and helper functions of the quaternion to Euler block.
package qte_pkg;

	localparam int IN_WIDTH = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int PROD_W = 32;
	localparam int SUM_W = 34;
	localparam int SW = 30;
	localparam int NSQ_W = 57;
	localparam int TRIAL_W = 60;
	localparam int ROOT_W = 29;
	localparam int SQRT_STEPS = 29;
	localparam int CW = 38;
	localparam int ANG_W = 34;
	localparam int OUT_W = 16;
	localparam int HALF_PI_Q13 = 12868;
	localparam int PI_Q13 = 25736;
	localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(64'sd268435456);

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] quat_w;
		logic signed [IN_WIDTH-1:0] quat_x;
		logic signed [IN_WIDTH-1:0] quat_y;
		logic signed [IN_WIDTH-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [14:0] angle_first;
		logic signed [15:0] angle_second;
		logic signed [15:0] angle_third;
	} angles_t;

	typedef struct packed {
		logic signed [SW-1:0]    s;
		logic signed [SUM_W-1:0] y1;
		logic signed [SUM_W-1:0] x1;
		logic signed [SUM_W-1:0] y2;
		logic signed [SUM_W-1:0] x2;
	} pass_t;

	typedef struct packed {
		logic [NSQ_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		pass_t             pass;
	} sqrt_t;

	typedef struct packed {
		logic signed [CW-1:0]    x;
		logic signed [CW-1:0]    y;
		logic signed [ANG_W-1:0] ang;
		logic                    zero;
	} lane_t;

	typedef lane_t [2:0] lanes_t;

	function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0:  v = 34'sh03243F6A8;
			5'd1:  v = 34'sh01DAC6705;
			5'd2:  v = 34'sh00FADBAFC;
			5'd3:  v = 34'sh007F56EA6;
			5'd4:  v = 34'sh003FEAB76;
			5'd5:  v = 34'sh001FFD55B;
			5'd6:  v = 34'sh000FFFAAA;
			5'd7:  v = 34'sh0007FFF55;
			5'd8:  v = 34'sh0003FFFEA;
			5'd9:  v = 34'sh0001FFFFD;
			5'd10: v = 34'sh0000FFFFF;
			5'd11: v = 34'sh00007FFFF;
			5'd12: v = 34'sh00003FFFF;
			5'd13: v = 34'sh00001FFFF;
			5'd14: v = 34'sh00000FFFF;
			5'd15: v = 34'sh000007FFF;
			5'd16: v = 34'sh000003FFF;
			5'd17: v = 34'sh000001FFF;
			5'd18: v = 34'sh000000FFF;
			5'd19: v = 34'sh0000007FF;
			5'd20: v = 34'sh0000003FF;
			5'd21: v = 34'sh0000001FF;
			5'd22: v = 34'sh0000000FF;
			5'd23: v = 34'sh00000007F;
			5'd24: v = 34'sh00000003F;
			5'd25: v = 34'sh00000001F;
			5'd26: v = 34'sh00000000F;
			5'd27: v = 34'sh000000008;
			5'd28: v = 34'sh000000004;
			5'd29: v = 34'sh000000002;
			5'd30: v = 34'sh000000001;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Folds a vector in the left half plane into the right half plane.
	function automatic lane_t prerot(input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] x);
		lane_t l;
		l.zero = (y == '0) && (x == '0);
		l.x = x;
		l.y = y;
		l.ang = '0;
		if (x[CW-1]) begin
			if (!y[CW-1]) begin
				l.x = y;
				l.y = -x;
				l.ang = atan_q30(5'd0) <<< 1;
			end else begin
				l.x = -y;
				l.y = x;
				l.ang = -(atan_q30(5'd0) <<< 1);
			end
		end
		return l;
	endfunction

	// Rounds a Q30 angle half up to Q13 and saturates it to the given limit.
	function automatic logic signed [OUT_W-1:0] round_sat(input lane_t l,
			input logic signed [17:0] limit);
		logic signed [ANG_W:0] t;
		logic signed [17:0]    r;
		logic signed [17:0]    o;
		t = {l.ang[ANG_W-1], l.ang} + (ANG_W+1)'(36'sd65536);
		r = t[ANG_W:17];
		o = r;
		if (r > limit)
			o = limit;
		if (r < -limit)
			o = -limit;
		if (l.zero)
			o = '0;
		return o[OUT_W-1:0];
	endfunction

endpackage

[src/qte_sqrt_cell.sv]
// One digit step of the pipelined integer square root chain.
module qte_sqrt_cell #(
	parameter int K = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_v,
	input  qte_pkg::sqrt_t    in_d,
	output logic              out_v,
	output qte_pkg::sqrt_t    out_d
);

	logic [qte_pkg::TRIAL_W-1:0] trial;
	logic [qte_pkg::TRIAL_W-1:0] rem_ext;
	qte_pkg::sqrt_t              nxt;

	always_comb begin
		trial = (qte_pkg::TRIAL_W'(in_d.root) << (K + 1))
			+ (qte_pkg::TRIAL_W'(1) << (2 * K));
		rem_ext = qte_pkg::TRIAL_W'(in_d.rem);
		nxt = in_d;
		if (rem_ext >= trial) begin
			nxt.rem = qte_pkg::NSQ_W'(rem_ext - trial);
			nxt.root = in_d.root | (qte_pkg::ROOT_W'(1) << K);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (adv) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_d <= nxt;
		end
	end

endmodule

[src/qte_cordic_cell.sv]
// One vectoring CORDIC iteration applied to all three angle lanes.
module qte_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_v,
	input  qte_pkg::lanes_t   in_l,
	output logic              out_v,
	output qte_pkg::lanes_t   out_l
);

	qte_pkg::lanes_t nxt;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nxt[i] = in_l[i];
			if (!in_l[i].y[qte_pkg::CW-1]) begin
				nxt[i].x = in_l[i].x + (in_l[i].y >>> STAGE);
				nxt[i].y = in_l[i].y - (in_l[i].x >>> STAGE);
				nxt[i].ang = in_l[i].ang + qte_pkg::atan_q30(5'(STAGE));
			end else begin
				nxt[i].x = in_l[i].x - (in_l[i].y >>> STAGE);
				nxt[i].y = in_l[i].y + (in_l[i].x >>> STAGE);
				nxt[i].ang = in_l[i].ang - qte_pkg::atan_q30(5'(STAGE));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (adv) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_l <= nxt;
		end
	end

endmodule

[src/quaternion_to_euler.sv]
// Top level of the pipelined quaternion to Euler angle converter.
//
// The quat channel takes one quaternion (w, x, y, z, signed Q1.14) per
// transfer, and the angles channel returns three Euler angles in radians,
// the first in signed Q1.13 and the others in signed Q2.13, per transfer, in input order, one result per quaternion.
// The datapath is a fixed pipeline: products, sums and clamping, the sine
// square term, a chain of 29 square root cells, a quadrant fold stage, a
// chain of CORDIC_STAGES vectoring cells and an output register.
// Throughput is one transfer per cycle while the pipeline advances; every
// cell holds a different quaternion.
// The whole pipeline advances together whenever the output register is
// empty or its result is taken in that cycle, and quat_ready follows the
// same condition. A stalled receiver therefore holds the pipeline and the
// input channel until the result is taken.
// Reset clears every valid bit; no result is pending afterward and the
// block is ready at once.
`include "assert_macros.svh"

module quaternion_to_euler #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              quat_valid,
	output logic              quat_ready,
	input  qte_pkg::quat_t    quat,
	output logic              angle_valid,
	input  logic              angle_ready,
	output qte_pkg::angles_t  angles
);

	localparam int NS = qte_pkg::SQRT_STEPS;

	logic adv;

	logic                               v_s1;
	logic signed [qte_pkg::PROD_W-1:0]  ww_s1, wx_s1, wy_s1, wz_s1, xx_s1;
	logic signed [qte_pkg::PROD_W-1:0]  xy_s1, xz_s1, yy_s1, yz_s1, zz_s1;

	logic                               v_s2;
	qte_pkg::pass_t                     p_s2;
	logic signed [qte_pkg::SUM_W-1:0]   sraw;
	logic signed [qte_pkg::SUM_W-1:0]   sclamp;
	logic signed [qte_pkg::SUM_W-1:0]   ww_e, xx_e, yy_e, zz_e;

	logic [qte_pkg::ROOT_W-1:0]         smag;
	logic [2*qte_pkg::ROOT_W-1:0]       ssq;

	logic                               sq_v [0:NS];
	qte_pkg::sqrt_t                     sq_d [0:NS];

	logic                               cd_v [0:CORDIC_STAGES];
	qte_pkg::lanes_t                    cd_l [0:CORDIC_STAGES];
	qte_pkg::lanes_t                    fold;
	qte_pkg::pass_t                     pe;

	logic                               out_v_q;
	qte_pkg::angles_t                   out_q;

	assign adv = !out_v_q || angle_ready;
	assign quat_ready = adv;
	assign angle_valid = out_v_q;
	assign angles = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			sq_v[0] <= 1'b0;
			cd_v[0] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= quat_valid;
			v_s2 <= v_s1;
			sq_v[0] <= v_s2;
			cd_v[0] <= sq_v[NS];
			out_v_q <= cd_v[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s1 <= quat.quat_w * quat.quat_w;
			wx_s1 <= quat.quat_w * quat.quat_x;
			wy_s1 <= quat.quat_w * quat.quat_y;
			wz_s1 <= quat.quat_w * quat.quat_z;
			xx_s1 <= quat.quat_x * quat.quat_x;
			xy_s1 <= quat.quat_x * quat.quat_y;
			xz_s1 <= quat.quat_x * quat.quat_z;
			yy_s1 <= quat.quat_y * quat.quat_y;
			yz_s1 <= quat.quat_y * quat.quat_z;
			zz_s1 <= quat.quat_z * quat.quat_z;
		end
	end

	always_comb begin
		ww_e = qte_pkg::SUM_W'(ww_s1);
		xx_e = qte_pkg::SUM_W'(xx_s1);
		yy_e = qte_pkg::SUM_W'(yy_s1);
		zz_e = qte_pkg::SUM_W'(zz_s1);
		sraw = (qte_pkg::SUM_W'(wx_s1) - qte_pkg::SUM_W'(yz_s1)) <<< 1;
		sclamp = sraw;
		if (sraw > qte_pkg::ONE_Q28)
			sclamp = qte_pkg::ONE_Q28;
		if (sraw < -qte_pkg::ONE_Q28)
			sclamp = -qte_pkg::ONE_Q28;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2.s <= sclamp[qte_pkg::SW-1:0];
			p_s2.y1 <= (qte_pkg::SUM_W'(xz_s1) + qte_pkg::SUM_W'(wy_s1)) <<< 1;
			p_s2.x1 <= ww_e - xx_e - yy_e + zz_e;
			p_s2.y2 <= (qte_pkg::SUM_W'(xy_s1) + qte_pkg::SUM_W'(wz_s1)) <<< 1;
			p_s2.x2 <= ww_e - xx_e + yy_e - zz_e;
		end
	end

	always_comb begin
		smag = p_s2.s[qte_pkg::SW-1] ? qte_pkg::ROOT_W'(-p_s2.s)
			: qte_pkg::ROOT_W'(p_s2.s);
		ssq = smag * smag;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_d[0].rem <= qte_pkg::NSQ_W'((58'd1 << 56) - ssq);
			sq_d[0].root <= '0;
			sq_d[0].pass <= p_s2;
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_sqrt
		qte_sqrt_cell #(
			.K(NS - 1 - j)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.in_v(sq_v[j]),
			.in_d(sq_d[j]),
			.out_v(sq_v[j+1]),
			.out_d(sq_d[j+1])
		);
	end

	always_comb begin
		pe = sq_d[NS].pass;
		fold[0] = qte_pkg::prerot(qte_pkg::CW'(pe.s),
			qte_pkg::CW'({1'b0, sq_d[NS].root}));
		fold[1] = qte_pkg::prerot(qte_pkg::CW'(pe.y1), qte_pkg::CW'(pe.x1));
		fold[2] = qte_pkg::prerot(qte_pkg::CW'(pe.y2), qte_pkg::CW'(pe.x2));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cd_l[0] <= fold;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		qte_cordic_cell #(
			.STAGE(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.in_v(cd_v[i]),
			.in_l(cd_l[i]),
			.out_v(cd_v[i+1]),
			.out_l(cd_l[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.angle_first <= 15'(qte_pkg::round_sat(cd_l[CORDIC_STAGES][0],
				18'(qte_pkg::HALF_PI_Q13)));
			out_q.angle_second <= qte_pkg::round_sat(cd_l[CORDIC_STAGES][1],
				18'(qte_pkg::PI_Q13));
			out_q.angle_third <= qte_pkg::round_sat(cd_l[CORDIC_STAGES][2],
				18'(qte_pkg::PI_Q13));
		end
	end

	`ASSERT_CLK(a_out_load, (adv && cd_v[CORDIC_STAGES]) |=> angle_valid)
	`ASSERT_NEVER(a_first_range, angle_valid && (angles.angle_first > 15'sd12868 || angles.angle_first < -15'sd12868))
	`ASSERT_NEVER(a_third_range, angle_valid && (angles.angle_third > 16'sd25736 || angles.angle_third < -16'sd25736))

endmodule
